FILE: rtl/sgdmf_pkg.sv
// Shared package for the SGD matrix-factorization update engine.
// Holds the function and state codes, the fixed widths and the default sizes.
// No dependencies.
`default_nettype none
package sgdmf_pkg;

  localparam int unsigned UserRowsDefault = 65536;
  localparam int unsigned ItemRowsDefault = 32768;
  localparam int unsigned LatentDefault   = 20;

  localparam int unsigned CfgIdxW = 2;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] CfgStep = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgReg  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgPmax = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgPmin = 2'd3;

  localparam logic [23:0] StepReset = 24'd16777;
  localparam logic [23:0] RegReset  = 24'd16777;

  typedef enum logic [2:0] {
    FuncWrUser = 3'd0,
    FuncWrItem = 3'd1,
    FuncRdUser = 3'd2,
    FuncRdItem = 3'd3,
    FuncTrain  = 3'd4
  } func_e;

  typedef enum logic [3:0] {
    StIdle,
    StRdWait,
    StDotRd,
    StDotMul,
    StDotAcc,
    StResid,
    StUpdRd,
    StUpdMul1,
    StUpdTerm,
    StUpdMul2,
    StUpdWr,
    StOut
  } state_e;

  // Saturate a 64-bit signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sd2147483647) r = 32'sh7FFFFFFF;
    else if (x < -64'sd2147483648) r = 32'sh80000000;
    else r = x[31:0];
    return r;
  endfunction

  // Round a Q.48 value to Q.24: add half an LSB, then floor shift.
  function automatic logic signed [63:0] round24(input logic signed [63:0] x);
    logic signed [63:0] y;
    y = x + 64'sd8388608;
    return y >>> 24;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/sgd_matrix_factorization_update.sv
// SGD matrix-factorization update engine: user and item factor tables in Q8.24
// held in two single-port synchronous memories, one train sequencer.
// Depends on sgdmf_pkg.
//
// One beat in, one beat out, and one beat is worked on at a time: a new beat is
// accepted only once the sequencer is back in idle. An element write passes
// through the access and output states, an element read through the access,
// data capture and output states. A train beat walks the rows three times
// through the memories: the dot product steps through read, multiply and
// accumulate for each latent element, and each of the two row updates steps
// through read, multiply, term, multiply by the step size and write for each
// element. The sequencer returns to idle as the result is loaded into the
// output register. The output register lets the next beat be accepted while a
// result still waits; the sequencer then holds its last state until that
// result is taken. The memories have no reset; reading an element that was
// never written gives an undefined value.
`default_nettype none
module sgd_matrix_factorization_update #(
  parameter int unsigned USER_ROWS = sgdmf_pkg::UserRowsDefault,
  parameter int unsigned ITEM_ROWS = sgdmf_pkg::ItemRowsDefault,
  parameter int unsigned LATENT    = sgdmf_pkg::LatentDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [1:0]          cfg_index_i,
  input  wire logic [31:0]         cfg_data_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [2:0]          func_i,
  input  wire logic [15:0]         user_index_i,
  input  wire logic [14:0]         item_index_i,
  input  wire logic [5:0]          element_index_i,
  input  wire logic signed [31:0]  factor_value_i,
  input  wire logic [7:0]          rating_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic signed [31:0]       read_value_o,
  output logic signed [31:0]       prediction_o,
  output logic signed [31:0]       residual_o
);

  localparam int unsigned UDepth = USER_ROWS * LATENT;
  localparam int unsigned IDepth = ITEM_ROWS * LATENT;
  localparam int unsigned UAw = (UDepth > 1) ? $clog2(UDepth) : 1;
  localparam int unsigned IAw = (IDepth > 1) ? $clog2(IDepth) : 1;
  localparam int unsigned EW  = (LATENT > 1) ? $clog2(LATENT) : 1;
  localparam int unsigned CW  = $clog2(LATENT + 1);

  // Configuration registers.
  logic [23:0]        step_q, reg_q;
  logic signed [31:0] pmax_q, pmin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= sgdmf_pkg::StepReset;
      reg_q  <= sgdmf_pkg::RegReset;
      pmax_q <= 32'sh7FFFFFFF;
      pmin_q <= 32'sh80000000;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        sgdmf_pkg::CfgStep: step_q <= cfg_data_i[23:0];
        sgdmf_pkg::CfgReg:  reg_q  <= cfg_data_i[23:0];
        sgdmf_pkg::CfgPmax: pmax_q <= cfg_data_i;
        sgdmf_pkg::CfgPmin: pmin_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Factor memories.
  logic signed [31:0] umem [UDepth];
  logic signed [31:0] imem [IDepth];
  logic [UAw-1:0]     u_addr;
  logic [IAw-1:0]     i_addr;
  logic               u_we, i_we;
  logic signed [31:0] u_wdata, i_wdata;
  logic signed [31:0] u_rdata_q, i_rdata_q;

  always_ff @(posedge clk_i) begin
    if (u_we) umem[u_addr] <= u_wdata;
    u_rdata_q <= umem[u_addr];
  end

  always_ff @(posedge clk_i) begin
    if (i_we) imem[i_addr] <= i_wdata;
    i_rdata_q <= imem[i_addr];
  end

  // Sequencer registers.
  sgdmf_pkg::state_e  state_q, state_d;
  logic [2:0]         func_q, func_d;
  logic [UAw-1:0]     ubase_q, ubase_d;
  logic [IAw-1:0]     ibase_q, ibase_d;
  logic [EW-1:0]      elem_q, elem_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic               phase_q, phase_d;   // 0: user row update, 1: item row update
  logic               ok_q, ok_d;
  logic signed [31:0] wval_q, wval_d;
  logic [7:0]         rating_q, rating_d;
  logic signed [63:0] prod_q, prod_d;
  logic signed [63:0] prod2_q, prod2_d;
  logic signed [31:0] self_q, self_d;
  logic signed [31:0] term_q, term_d;
  logic signed [47:0] acc_q, acc_d;
  logic signed [31:0] pred_q, pred_d;
  logic signed [31:0] res_q, res_d;
  logic signed [31:0] rdv_q, rdv_d;
  logic               ov_q, ov_d;
  logic signed [31:0] ord_q, ord_d, opred_q, opred_d, ores_q, ores_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sgdmf_pkg::StIdle;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q   <= func_d;   ubase_q <= ubase_d; ibase_q <= ibase_d;
    elem_q   <= elem_d;   cnt_q   <= cnt_d;   phase_q <= phase_d;
    ok_q     <= ok_d;     wval_q  <= wval_d;  rating_q <= rating_d;
    prod_q   <= prod_d;   prod2_q <= prod2_d; self_q  <= self_d;
    term_q   <= term_d;   acc_q   <= acc_d;   pred_q  <= pred_d;
    res_q    <= res_d;    rdv_q   <= rdv_d;   ord_q   <= ord_d;
    opred_q  <= opred_d;  ores_q  <= ores_d;
  end

  logic signed [63:0] acc_sat_in, clamp_a, res_full, t_sum, t_rnd, delta, newv;
  logic signed [31:0] clamp_p, t_sat, other;
  logic               user_ok, item_ok, elem_ok;

  assign in_ready_o   = (state_q == sgdmf_pkg::StIdle);
  assign out_valid_o  = ov_q;
  assign read_value_o = ord_q;
  assign prediction_o = opred_q;
  assign residual_o   = ores_q;

  assign user_ok = {16'd0, user_index_i} < 32'(USER_ROWS);
  assign item_ok = {17'd0, item_index_i} < 32'(ITEM_ROWS);
  assign elem_ok = {26'd0, element_index_i} < 32'(LATENT);

  // Next state and datapath.
  always_comb begin
    state_d = state_q; func_d = func_q; ubase_d = ubase_q; ibase_d = ibase_q;
    elem_d = elem_q; cnt_d = cnt_q; phase_d = phase_q; ok_d = ok_q;
    wval_d = wval_q; rating_d = rating_q; prod_d = prod_q; prod2_d = prod2_q;
    self_d = self_q; term_d = term_q; acc_d = acc_q; pred_d = pred_q;
    res_d = res_q; rdv_d = rdv_q; ov_d = ov_q;
    ord_d = ord_q; opred_d = opred_q; ores_d = ores_q;
    u_addr = ubase_q + UAw'(elem_q);
    i_addr = ibase_q + IAw'(elem_q);
    u_we = 1'b0; i_we = 1'b0;
    u_wdata = wval_q; i_wdata = wval_q;

    acc_sat_in = 64'(acc_q);
    clamp_a    = 64'(sgdmf_pkg::sat32(acc_sat_in));
    if (clamp_a > 64'(pmax_q)) clamp_a = 64'(pmax_q);
    if (clamp_a < 64'(pmin_q)) clamp_a = 64'(pmin_q);
    clamp_p  = clamp_a[31:0];
    res_full = 64'(clamp_p) - $signed({32'd0, rating_q, 24'd0});
    other    = phase_q ? u_rdata_q : i_rdata_q;
    t_sum    = prod_q + prod2_q;
    t_rnd    = sgdmf_pkg::round24(t_sum);
    t_sat    = sgdmf_pkg::sat32(t_rnd);
    delta    = sgdmf_pkg::round24(prod_q);
    newv     = 64'(self_q) - delta;

    if (ov_q && out_ready_i) ov_d = 1'b0;

    unique case (state_q)
      sgdmf_pkg::StIdle: begin
        if (in_valid_i && in_ready_o) begin
          func_d   = func_i;
          ubase_d  = UAw'(user_index_i * LATENT);
          ibase_d  = IAw'(item_index_i * LATENT);
          elem_d   = EW'(element_index_i);
          wval_d   = factor_value_i;
          rating_d = rating_i;
          rdv_d = '0; pred_d = '0; res_d = '0;
          unique case (func_i)
            sgdmf_pkg::FuncWrUser, sgdmf_pkg::FuncRdUser: begin
              ok_d = user_ok && elem_ok;
              state_d = sgdmf_pkg::StRdWait;
            end
            sgdmf_pkg::FuncWrItem, sgdmf_pkg::FuncRdItem: begin
              ok_d = item_ok && elem_ok;
              state_d = sgdmf_pkg::StRdWait;
            end
            sgdmf_pkg::FuncTrain: begin
              ok_d = user_ok && item_ok;
              elem_d = '0; cnt_d = '0; acc_d = '0; phase_d = 1'b0;
              state_d = (user_ok && item_ok) ? sgdmf_pkg::StDotRd : sgdmf_pkg::StOut;
            end
            default: state_d = sgdmf_pkg::StOut;
          endcase
        end
      end
      // Single element access: write now, or read data lands next cycle.
      sgdmf_pkg::StRdWait: begin
        if (func_q == sgdmf_pkg::FuncWrUser) u_we = ok_q;
        if (func_q == sgdmf_pkg::FuncWrItem) i_we = ok_q;
        state_d = (func_q == sgdmf_pkg::FuncRdUser || func_q == sgdmf_pkg::FuncRdItem)
                  ? sgdmf_pkg::StDotMul : sgdmf_pkg::StOut;
        if (func_q != sgdmf_pkg::FuncTrain && func_q != sgdmf_pkg::FuncRdUser &&
            func_q != sgdmf_pkg::FuncRdItem) state_d = sgdmf_pkg::StOut;
      end
      sgdmf_pkg::StDotRd: state_d = sgdmf_pkg::StDotMul;
      sgdmf_pkg::StDotMul: begin
        if (func_q == sgdmf_pkg::FuncTrain) begin
          prod_d  = 64'(u_rdata_q) * 64'(i_rdata_q);
          state_d = sgdmf_pkg::StDotAcc;
        end else begin
          if (ok_q) rdv_d = (func_q == sgdmf_pkg::FuncRdUser) ? u_rdata_q : i_rdata_q;
          state_d = sgdmf_pkg::StOut;
        end
      end
      // Accumulate the rounded product; next element or finish.
      sgdmf_pkg::StDotAcc: begin
        acc_d = acc_q + 48'(sgdmf_pkg::round24(prod_q));
        if (cnt_q == CW'(LATENT - 1)) begin
          state_d = sgdmf_pkg::StResid;
        end else begin
          cnt_d = cnt_q + 1'b1; elem_d = elem_q + 1'b1;
          state_d = sgdmf_pkg::StDotRd;
        end
      end
      sgdmf_pkg::StResid: begin
        pred_d = clamp_p;
        res_d  = sgdmf_pkg::sat32(res_full);
        elem_d = '0; cnt_d = '0; phase_d = 1'b0;
        state_d = sgdmf_pkg::StUpdRd;
      end
      sgdmf_pkg::StUpdRd: state_d = sgdmf_pkg::StUpdMul1;
      // residual*other and regularization*self.
      sgdmf_pkg::StUpdMul1: begin
        self_d  = phase_q ? i_rdata_q : u_rdata_q;
        prod_d  = 64'(res_q) * 64'(other);
        prod2_d = $signed({40'd0, reg_q}) * 64'(phase_q ? i_rdata_q : u_rdata_q);
        state_d = sgdmf_pkg::StUpdTerm;
      end
      sgdmf_pkg::StUpdTerm: begin
        term_d  = t_sat;
        state_d = sgdmf_pkg::StUpdMul2;
      end
      sgdmf_pkg::StUpdMul2: begin
        prod_d  = $signed({40'd0, step_q}) * 64'(term_q);
        state_d = sgdmf_pkg::StUpdWr;
      end
      // Write back the new element; user row first, then item row.
      sgdmf_pkg::StUpdWr: begin
        u_wdata = sgdmf_pkg::sat32(newv);
        i_wdata = sgdmf_pkg::sat32(newv);
        u_we = !phase_q;
        i_we = phase_q;
        if (cnt_q == CW'(LATENT - 1)) begin
          elem_d = '0; cnt_d = '0;
          if (phase_q) begin
            state_d = sgdmf_pkg::StOut;
          end else begin
            phase_d = 1'b1;
            state_d = sgdmf_pkg::StUpdRd;
          end
        end else begin
          cnt_d = cnt_q + 1'b1; elem_d = elem_q + 1'b1;
          state_d = sgdmf_pkg::StUpdRd;
        end
      end
      // Load the output register once the previous result is gone or leaving.
      sgdmf_pkg::StOut: begin
        if (!ov_q || out_ready_i) begin
          ov_d    = 1'b1;
          ord_d   = rdv_q;
          opred_d = pred_q;
          ores_d  = res_q;
          state_d = sgdmf_pkg::StIdle;
        end
      end
      default: state_d = sgdmf_pkg::StIdle;
    endcase
  end

endmodule
`default_nettype wire
